@@ src/vehicle_footprint_collision_check_core_assert.svh @@
// Assertion macros for the footprint collision check core.
// Used by the port-level checker; expects signals named clock and reset in scope.
`ifndef VEHICLE_FOOTPRINT_COLLISION_CHECK_CORE_ASSERT_SVH
`define VEHICLE_FOOTPRINT_COLLISION_CHECK_CORE_ASSERT_SVH

// same-cycle implication
`define VFCC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VFCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/vfcc_pkg.sv @@
// Shared types and constants for the footprint collision check core.
// No dependencies.
package vfcc_pkg;

   localparam int CORDIC_STEPS = 14;
   localparam int ITER_W       = 4;
   localparam int CX_W         = 20;   // CORDIC x/y datapath
   localparam int ANG_W        = 18;   // angles, 2^-13 rad units
   localparam int TRIG_W       = 16;   // clamped Q1.14

   localparam logic signed [CX_W-1:0]  CORDIC_GAIN  = 20'sd9949;
   localparam logic signed [CX_W-1:0]  TRIG_ONE     = 20'sd16384;
   localparam logic signed [ANG_W-1:0] HALF_TURN    = 18'sd25736;
   localparam logic signed [ANG_W-1:0] FULL_TURN    = 18'sd51472;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 18'sd12868;

   localparam logic [3:0] NUM_POINTS = 4'd10;
   localparam logic [3:0] LAST_POINT = 4'd9;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0]  REG_LENGTH   = 4'd0;
   localparam logic [CSR_IDX_W-1:0]  REG_WIDTH    = 4'd1;
   localparam logic [CSR_DATA_W-1:0] LENGTH_RESET = 8'd40;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET  = 8'd20;

   typedef struct packed {
      logic               opcode;
      logic [9:0]         cell_row;
      logic [10:0]        cell_col;
      logic               cell_occupied;
      logic [13:0]        pose_row;
      logic [14:0]        pose_col;
      logic signed [15:0] heading;
   } req_payload_type;

   typedef struct packed {
      logic       is_free;
      logic [3:0] first_blocked_point;
      logic       outside_map;
   } rsp_payload_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   // arctangent table, rounded to nearest, 2^-13 rad units
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         4'd0:    v = 18'sd6434;
         4'd1:    v = 18'sd3798;
         4'd2:    v = 18'sd2007;
         4'd3:    v = 18'sd1019;
         4'd4:    v = 18'sd511;
         4'd5:    v = 18'sd256;
         4'd6:    v = 18'sd128;
         4'd7:    v = 18'sd64;
         4'd8:    v = 18'sd32;
         4'd9:    v = 18'sd16;
         4'd10:   v = 18'sd8;
         4'd11:   v = 18'sd4;
         4'd12:   v = 18'sd2;
         4'd13:   v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ src/vfcc_cordic.sv @@
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on vfcc_pkg.
module vfcc_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vfcc_pkg::cordic_cmd_type              cmd,
   input  logic signed [vfcc_pkg::CX_W-1:0]      x_init,
   input  logic signed [vfcc_pkg::CX_W-1:0]      y_init,
   input  logic signed [vfcc_pkg::ANG_W-1:0]     z_init,
   output logic signed [vfcc_pkg::CX_W-1:0]      x_out,
   output logic signed [vfcc_pkg::CX_W-1:0]      y_out,
   output logic signed [vfcc_pkg::ANG_W-1:0]     z_out,
   output logic                                  done
);
   import vfcc_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     vec_ff, vec_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic signed [CX_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic signed [CX_W-1:0]   x_sh, y_sh;
   logic signed [ANG_W-1:0]  at;
   logic                     neg_dir;

   always_comb begin
      x_sh = x_ff >>> iter_ff;
      y_sh = y_ff >>> iter_ff;
      at   = atan_entry(iter_ff);
      // vectoring drives y to zero, rotation drives z to zero
      neg_dir = vec_ff ? ~y_ff[CX_W-1] : z_ff[ANG_W-1];

      busy_in = busy_ff;
      done_in = 1'b0;
      vec_in  = vec_ff;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         vec_in  = cmd.vectoring;
         iter_in = '0;
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
      end else if (busy_ff) begin
         x_in    = neg_dir ? x_ff + y_sh : x_ff - y_sh;
         y_in    = neg_dir ? y_ff - x_sh : y_ff + x_sh;
         z_in    = neg_dir ? z_ff + at : z_ff - at;
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign done  = done_ff;

endmodule

@@ src/vfcc_isqrt.sv @@
// Bit-pair restoring integer square root, one result bit per cycle.
// Depends on vfcc_pkg (import only for house style).
module vfcc_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] radicand,
   output logic [15:0] root,
   output logic        busy
);
   import vfcc_pkg::*;

   logic [31:0] n_ff, n_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] bit_ff, bit_in;
   logic [32:0] trial;

   always_comb begin
      trial  = {1'b0, res_ff} + {1'b0, bit_ff};
      n_in   = n_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         n_in   = radicand;
         res_in = '0;
         bit_in = 32'h4000_0000;
      end else if (bit_ff != '0) begin
         if ({1'b0, n_ff} >= trial) begin
            n_in   = n_ff - trial[31:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      res_ff <= res_in;
   end

   assign root = res_ff[15:0];
   assign busy = (bit_ff != '0);

endmodule

@@ src/vfcc_map.sv @@
// One-bit occupancy memory: one write port, one registered read port,
// and a clearing sweep after reset. Depends on vfcc_pkg (import only).
module vfcc_map #(
   parameter  int DEPTH = 2097152,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_bit,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_bit,
   output logic          ready
);
   import vfcc_pkg::*;

   logic          mem [DEPTH];
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          rd_bit_ff;
   logic          we;
   logic [AW-1:0] wa;
   logic          wd;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
      we = clr_busy_ff | wr_en;
      wa = clr_busy_ff ? clr_addr_ff : wr_addr;
      wd = ~clr_busy_ff & wr_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_bit_ff <= mem[rd_addr];
      end
   end

   assign rd_bit = rd_bit_ff;
   assign ready  = ~clr_busy_ff;

endmodule

@@ src/vehicle_footprint_collision_check_core.sv @@
// Top level of the vehicle footprint collision check core.
// Depends on vfcc_pkg, vfcc_cordic, vfcc_isqrt and vfcc_map.
//
//   channel | direction | handshake            | word
//   req_    | in        | req_valid/req_ready  | req_payload_type (write cell or check pose)
//   rsp_    | out       | rsp_valid/rsp_ready  | rsp_payload_type (one per check)
//   csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata (length, width)
//
// A cell write goes straight into the map on accept. A check looks up the outline
// points in order up to and including the deciding one: one CORDIC unit runs the
// inner-angle vectoring and three rotations of 14 steps each, one multiplier makes
// ten offsets, and the single map read port serves one point at a time through
// S_PT_CALC, S_PT_READ and S_PT_EVAL.
// After reset the map is swept to free while req_ready is low; csr writes are taken
// throughout. A result waiting on rsp_ready does not block the next req word; a
// finished check holds until the rsp register frees.
module vehicle_footprint_collision_check_core #(
   parameter int MAP_ROWS  = 1024,
   parameter int MAP_COLS  = 2048,
   parameter int FRAC_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  vfcc_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output vfcc_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vfcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vfcc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import vfcc_pkg::*;

   localparam int DEPTH   = MAP_ROWS * MAP_COLS;
   localparam int AW      = $clog2(DEPTH);
   localparam int RCW     = $clog2(MAP_ROWS);
   localparam int CCW     = $clog2(MAP_COLS);
   localparam int LIM_W   = 13;   // holds grid sizes up to 4096
   localparam int AFULL_W = 26;
   localparam int COORD_W = 19;   // point coordinates, Q.FRAC_BITS
   localparam int OFF_W   = 18;   // offsets, Q.FRAC_BITS
   localparam int PROD_W  = 34;
   localparam int SH_INT  = 14 - FRAC_BITS;
   localparam int SH_Q8   = 22 - FRAC_BITS;
   localparam logic signed [PROD_W-1:0] RND_INT = PROD_W'(64'sd1 << (13 - FRAC_BITS));
   localparam logic signed [PROD_W-1:0] RND_Q8  = PROD_W'(64'sd1 << (21 - FRAC_BITS));

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_VEC_WAIT  = 4'd1;
   localparam logic [3:0] S_ROT_START = 4'd2;
   localparam logic [3:0] S_ROT_WAIT  = 4'd3;
   localparam logic [3:0] S_MUL       = 4'd4;
   localparam logic [3:0] S_PT_CALC   = 4'd5;
   localparam logic [3:0] S_PT_READ   = 4'd6;
   localparam logic [3:0] S_PT_EVAL   = 4'd7;
   localparam logic [3:0] S_RESULT    = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic [7:0]              len_ff, len_in, wid_ff, wid_in;
   req_payload_type         pose_ff, pose_in;
   logic [6:0]              hl_ff, hl_in, tl_ff, tl_in;
   logic                    vec_got_ff, vec_got_in;
   logic signed [ANG_W-1:0] b_ff, b_in;
   logic [15:0]             h8_ff, h8_in;
   logic [1:0]              rot_idx_ff, rot_idx_in;
   logic                    flip_ff, flip_in;
   logic signed [TRIG_W-1:0] cos_ff [3];
   logic signed [TRIG_W-1:0] sin_ff [3];
   logic [3:0]              mul_cnt_ff, mul_cnt_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [3:0]              pidx_ff;
   logic                    pval_ff, pval_in;
   logic signed [OFF_W-1:0] offs_ff [10];
   logic [3:0]              pt_ff, pt_in;
   logic [RCW-1:0]          rcell_ff, rcell_in;
   logic [CCW-1:0]          ccell_ff, ccell_in;
   logic                    pout_ff, pout_in;
   rsp_payload_type         res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   logic                    req_fire, check_fire;
   logic [16:0]             len3;
   logic [16:0]             sq_sum;
   logic [LIM_W-1:0]        wr_row, wr_col;
   logic [AFULL_W-1:0]      wr_afull, rd_afull;

   cordic_cmd_type          cmd;
   logic signed [CX_W-1:0]  cx_init, cy_init, cx_out, cy_out;
   logic signed [ANG_W-1:0] cz_init, cz_out;
   logic                    cordic_done;
   logic                    sq_busy;
   logic [15:0]             sq_root;

   logic signed [ANG_W-1:0] ang_raw, ang_wrap, ang_fold;
   logic                    ang_flip;
   logic signed [CX_W-1:0]  xf, yf;
   logic signed [TRIG_W-1:0] cos_new, sin_new;

   logic signed [16:0]      mul_d;
   logic signed [TRIG_W-1:0] mul_t;
   logic signed [32:0]      mul_p;
   logic signed [PROD_W-1:0] rnd_sum, rnd_sh;

   logic signed [COORD_W-1:0] pc_ext, pr_ext, col_v, row_v;
   logic [COORD_W-1:0]      c_mag, r_mag, c_cell, r_cell;
   logic                    c_out, r_out;

   logic                    map_wr_en, map_rd_en, map_rd_bit, map_ready;
   logic [AW-1:0]           map_wr_addr, map_rd_addr;

   // ---------------- input side ----------------
   assign req_ready  = (state_ff == S_IDLE) && map_ready;
   assign req_fire   = req_valid && req_ready;
   assign check_fire = req_fire && (req_data.opcode == OP_CHECK);
   assign csr_ready  = 1'b1;

   // cell writes go straight into the map; out-of-grid writes are dropped
   always_comb begin
      wr_row      = {3'b0, req_data.cell_row};
      wr_col      = {2'b0, req_data.cell_col};
      wr_afull    = AFULL_W'(wr_row) * AFULL_W'(MAP_COLS) + AFULL_W'(wr_col);
      map_wr_addr = wr_afull[AW-1:0];
      map_wr_en   = req_fire && (req_data.opcode == OP_WRITE) &&
                    (wr_row < LIM_W'(MAP_ROWS)) && (wr_col < LIM_W'(MAP_COLS));
   end

   // floor(L/3) through a reciprocal multiply, exact for 8-bit L
   assign len3   = 17'(len_ff) * 17'd171;
   assign sq_sum = 17'(len_ff) * 17'(len_ff) + 17'(wid_ff) * 17'(wid_ff);

   // ---------------- angle preparation for rotations ----------------
   always_comb begin
      case (rot_idx_ff)
         2'd1:    ang_raw = ANG_W'(pose_ff.heading) - b_ff;
         2'd2:    ang_raw = ANG_W'(pose_ff.heading) + b_ff;
         default: ang_raw = ANG_W'(pose_ff.heading);
      endcase
      if (ang_raw > HALF_TURN) begin
         ang_wrap = ang_raw - FULL_TURN;
      end else if (ang_raw < -HALF_TURN) begin
         ang_wrap = ang_raw + FULL_TURN;
      end else begin
         ang_wrap = ang_raw;
      end
      // fold into the CORDIC range, negate the result afterwards
      ang_flip = 1'b1;
      if (ang_wrap > QUARTER_TURN) begin
         ang_fold = ang_wrap - HALF_TURN;
      end else if (ang_wrap < -QUARTER_TURN) begin
         ang_fold = ang_wrap + HALF_TURN;
      end else begin
         ang_fold = ang_wrap;
         ang_flip = 1'b0;
      end
   end

   // CORDIC command: vectoring on accept, rotation in S_ROT_START
   always_comb begin
      cmd.start     = check_fire || (state_ff == S_ROT_START);
      cmd.vectoring = (state_ff == S_IDLE);
      if (state_ff == S_IDLE) begin
         cx_init = {{(CX_W-16){1'b0}}, len_ff, 8'b0};
         cy_init = {{(CX_W-16){1'b0}}, wid_ff, 8'b0};
         cz_init = '0;
      end else begin
         cx_init = CORDIC_GAIN;
         cy_init = '0;
         cz_init = ang_fold;
      end
   end

   // undo the fold and clamp to one
   always_comb begin
      xf = flip_ff ? -cx_out : cx_out;
      yf = flip_ff ? -cy_out : cy_out;
      if (xf > TRIG_ONE) begin
         xf = TRIG_ONE;
      end else if (xf < -TRIG_ONE) begin
         xf = -TRIG_ONE;
      end
      if (yf > TRIG_ONE) begin
         yf = TRIG_ONE;
      end else if (yf < -TRIG_ONE) begin
         yf = -TRIG_ONE;
      end
      cos_new = xf[TRIG_W-1:0];
      sin_new = yf[TRIG_W-1:0];
   end

   // ---------------- offset multiplier ----------------
   // products 0..5: half, third, two thirds of L times heading cos/sin;
   // products 6..9: half diagonal times cos/sin of heading minus/plus inner angle
   always_comb begin
      case (mul_cnt_ff)
         4'd0, 4'd1: mul_d = {10'b0, hl_ff};
         4'd2, 4'd3: mul_d = {10'b0, tl_ff};
         4'd4, 4'd5: mul_d = {9'b0, tl_ff, 1'b0};
         default:    mul_d = {1'b0, h8_ff};
      endcase
      case (mul_cnt_ff)
         4'd6:    mul_t = cos_ff[1];
         4'd7:    mul_t = sin_ff[1];
         4'd8:    mul_t = cos_ff[2];
         4'd9:    mul_t = sin_ff[2];
         default: mul_t = mul_cnt_ff[0] ? sin_ff[0] : cos_ff[0];
      endcase
      mul_p   = mul_d * mul_t;
      prod_in = PROD_W'(mul_p);
      pval_in = (state_ff == S_MUL) && (mul_cnt_ff < NUM_POINTS);
      // round half up, then shift to Q.FRAC_BITS
      if (pidx_ff >= 4'd6) begin
         rnd_sum = prod_ff + RND_Q8;
         rnd_sh  = rnd_sum >>> SH_Q8;
      end else begin
         rnd_sum = prod_ff + RND_INT;
         rnd_sh  = rnd_sum >>> SH_INT;
      end
   end

   // ---------------- outline point and its cell ----------------
   always_comb begin
      pc_ext = {{(COORD_W-15){1'b0}}, pose_ff.pose_col};
      pr_ext = {{(COORD_W-14){1'b0}}, pose_ff.pose_row};
      unique case (pt_ff)
         4'd0: begin
            col_v = pc_ext + COORD_W'(offs_ff[0]);
            row_v = pr_ext + COORD_W'(offs_ff[1]);
         end
         4'd1: begin
            col_v = pc_ext + COORD_W'(offs_ff[6]);
            row_v = pr_ext + COORD_W'(offs_ff[7]);
         end
         4'd2: begin
            col_v = pc_ext + COORD_W'(offs_ff[6]) - COORD_W'(offs_ff[2]);
            row_v = pr_ext + COORD_W'(offs_ff[7]) - COORD_W'(offs_ff[3]);
         end
         4'd3: begin
            col_v = pc_ext + COORD_W'(offs_ff[6]) - COORD_W'(offs_ff[4]);
            row_v = pr_ext + COORD_W'(offs_ff[7]) - COORD_W'(offs_ff[5]);
         end
         4'd4: begin
            col_v = pc_ext - COORD_W'(offs_ff[8]);
            row_v = pr_ext - COORD_W'(offs_ff[9]);
         end
         4'd5: begin
            col_v = pc_ext - COORD_W'(offs_ff[0]);
            row_v = pr_ext - COORD_W'(offs_ff[1]);
         end
         4'd6: begin
            col_v = pc_ext - COORD_W'(offs_ff[6]);
            row_v = pr_ext - COORD_W'(offs_ff[7]);
         end
         4'd7: begin
            col_v = pc_ext - COORD_W'(offs_ff[6]) + COORD_W'(offs_ff[2]);
            row_v = pr_ext - COORD_W'(offs_ff[7]) + COORD_W'(offs_ff[3]);
         end
         4'd8: begin
            col_v = pc_ext - COORD_W'(offs_ff[6]) + COORD_W'(offs_ff[4]);
            row_v = pr_ext - COORD_W'(offs_ff[7]) + COORD_W'(offs_ff[5]);
         end
         default: begin
            col_v = pc_ext + COORD_W'(offs_ff[8]);
            row_v = pr_ext + COORD_W'(offs_ff[9]);
         end
      endcase
      // truncate toward zero; anything in (-1, 0) lands on cell 0
      c_mag  = col_v[COORD_W-1] ? COORD_W'(-col_v) : COORD_W'(col_v);
      r_mag  = row_v[COORD_W-1] ? COORD_W'(-row_v) : COORD_W'(row_v);
      c_cell = c_mag >> FRAC_BITS;
      r_cell = r_mag >> FRAC_BITS;
      c_out  = col_v[COORD_W-1] ? (c_cell != '0) : (c_cell >= COORD_W'(MAP_COLS));
      r_out  = row_v[COORD_W-1] ? (r_cell != '0) : (r_cell >= COORD_W'(MAP_ROWS));
      ccell_in = col_v[COORD_W-1] ? '0 : c_cell[CCW-1:0];
      rcell_in = row_v[COORD_W-1] ? '0 : r_cell[RCW-1:0];
      pout_in  = c_out || r_out;

      rd_afull    = AFULL_W'(rcell_ff) * AFULL_W'(MAP_COLS) + AFULL_W'(ccell_ff);
      map_rd_addr = rd_afull[AW-1:0];
      map_rd_en   = (state_ff == S_PT_READ) && !pout_ff;
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      wid_in       = wid_ff;
      pose_in      = pose_ff;
      hl_in        = hl_ff;
      tl_in        = tl_ff;
      vec_got_in   = vec_got_ff;
      b_in         = b_ff;
      h8_in        = h8_ff;
      rot_idx_in   = rot_idx_ff;
      flip_in      = flip_ff;
      mul_cnt_in   = mul_cnt_ff;
      pt_in        = pt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == REG_LENGTH) begin
            len_in = csr_wdata;
         end else if (csr_index == REG_WIDTH) begin
            wid_in = csr_wdata;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (check_fire) begin
               pose_in    = req_data;
               hl_in      = len_ff[7:1];
               tl_in      = len3[15:9];
               vec_got_in = 1'b0;
               state_in   = S_VEC_WAIT;
            end
         end
         S_VEC_WAIT: begin
            if (cordic_done) begin
               b_in       = cz_out;
               vec_got_in = 1'b1;
            end
            if (vec_got_ff && !sq_busy) begin
               h8_in      = sq_root;
               rot_idx_in = '0;
               state_in   = S_ROT_START;
            end
         end
         S_ROT_START: begin
            flip_in  = ang_flip;
            state_in = S_ROT_WAIT;
         end
         S_ROT_WAIT: begin
            if (cordic_done) begin
               if (rot_idx_ff == 2'd2) begin
                  mul_cnt_in = '0;
                  state_in   = S_MUL;
               end else begin
                  rot_idx_in = rot_idx_ff + 1'b1;
                  state_in   = S_ROT_START;
               end
            end
         end
         S_MUL: begin
            if (mul_cnt_ff == NUM_POINTS) begin
               pt_in    = '0;
               state_in = S_PT_CALC;
            end else begin
               mul_cnt_in = mul_cnt_ff + 1'b1;
            end
         end
         S_PT_CALC: begin
            state_in = S_PT_READ;
         end
         S_PT_READ: begin
            if (pout_ff) begin
               res_in.is_free             = 1'b0;
               res_in.first_blocked_point = pt_ff;
               res_in.outside_map         = 1'b1;
               state_in                   = S_RESULT;
            end else begin
               state_in = S_PT_EVAL;
            end
         end
         S_PT_EVAL: begin
            if (map_rd_bit) begin
               res_in.is_free             = 1'b0;
               res_in.first_blocked_point = pt_ff;
               res_in.outside_map         = 1'b0;
               state_in                   = S_RESULT;
            end else if (pt_ff == LAST_POINT) begin
               res_in.is_free             = 1'b1;
               res_in.first_blocked_point = NUM_POINTS;
               res_in.outside_map         = 1'b0;
               state_in                   = S_RESULT;
            end else begin
               pt_in    = pt_ff + 1'b1;
               state_in = S_PT_CALC;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= LENGTH_RESET;
         wid_ff       <= WIDTH_RESET;
         vec_got_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pval_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         wid_ff       <= wid_in;
         vec_got_ff   <= vec_got_in;
         rsp_valid_ff <= rsp_valid_in;
         pval_ff      <= pval_in;
      end
   end

   always_ff @(posedge clock) begin
      pose_ff     <= pose_in;
      hl_ff       <= hl_in;
      tl_ff       <= tl_in;
      b_ff        <= b_in;
      h8_ff       <= h8_in;
      rot_idx_ff  <= rot_idx_in;
      flip_ff     <= flip_in;
      mul_cnt_ff  <= mul_cnt_in;
      prod_ff     <= prod_in;
      pidx_ff     <= mul_cnt_ff;
      pt_ff       <= pt_in;
      rcell_ff    <= rcell_in;
      ccell_ff    <= ccell_in;
      pout_ff     <= pout_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if ((state_ff == S_ROT_WAIT) && cordic_done) begin
         cos_ff[rot_idx_ff] <= cos_new;
         sin_ff[rot_idx_ff] <= sin_new;
      end
      if (pval_ff) begin
         offs_ff[pidx_ff] <= rnd_sh[OFF_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- units ----------------
   vfcc_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .x_init (cx_init),
      .y_init (cy_init),
      .z_init (cz_init),
      .x_out  (cx_out),
      .y_out  (cy_out),
      .z_out  (cz_out),
      .done   (cordic_done)
   );

   vfcc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (check_fire),
      .radicand ({1'b0, sq_sum, 14'b0}),
      .root     (sq_root),
      .busy     (sq_busy)
   );

   vfcc_map #(
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_bit  (req_data.cell_occupied),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_bit  (map_rd_bit),
      .ready   (map_ready)
   );

endmodule

@@ src/vfcc_checker.sv @@
// Port-level checker for the footprint collision check core, bound to the top.
// Depends on vfcc_pkg and vehicle_footprint_collision_check_core_assert.svh.
`include "vehicle_footprint_collision_check_core_assert.svh"

module vfcc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input vfcc_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input vfcc_pkg::rsp_payload_type rsp_data
);
   import vfcc_pkg::*;

   `VFCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")
   `VFCC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp word changed while stalled")
   `VFCC_ASSERT_SAME(a_free_fields, rsp_valid && rsp_data.is_free, (rsp_data.first_blocked_point == NUM_POINTS) && !rsp_data.outside_map, "free result with blocking fields")
   `VFCC_ASSERT_SAME(a_blocked_idx, rsp_valid && !rsp_data.is_free, rsp_data.first_blocked_point < NUM_POINTS, "blocked result without point index")
   `VFCC_ASSERT_NEXT(a_write_silent, req_valid && req_ready && (req_data.opcode == OP_WRITE) && !rsp_valid, !rsp_valid, "cell write produced a result")

endmodule

bind vehicle_footprint_collision_check_core vfcc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
